// File: rtl/core/assert_macros.svh
// Assertion helpers used by sai_datapath. Each use expands to one labeled
// concurrent assertion clocked on the rising edge and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant that must hold at every clock edge out of reset.
`define SAI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define SAI_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  `SAI_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

// Next-cycle implication.
`define SAI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `SAI_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

// File: rtl/core/sai_pkg.sv
`timescale 1ns / 1ps
package sai_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 32;
  localparam int INDEX_W  = 8;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_GET    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd;
    logic step;
    logic done;
  } sai_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic skip;
    logic rd_last;
    logic step_last;
  } sai_stat_t;

endpackage

// File: rtl/core/sai_ram.sv
`timescale 1ns / 1ps
module sai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sai_ctrl.sv
`timescale 1ns / 1ps
module sai_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output sai_pkg::sai_cmd_t cmd_o,
  input  sai_pkg::sai_stat_t stat_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_STEP,
    S_FIN
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_READ;
            busy_q  <= 1'b1;
          end
        end
        S_READ: begin
          if (stat_i.skip || stat_i.rd_last) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (stat_i.step_last) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_READ;
          end
        end
        S_FIN: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy       = busy_q;
  assign cmd_o.load = start && !busy_q;
  assign cmd_o.rd   = (state_q == S_READ);
  assign cmd_o.step = (state_q == S_STEP);
  assign cmd_o.done = (state_q == S_FIN);

endmodule

// File: rtl/core/sai_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sai_datapath #(
  parameter int DEPTH     = sai_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = sai_pkg::KEY_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sai_pkg::sai_cmd_t              cmd_i,
  output sai_pkg::sai_stat_t             stat_o,
  input  logic                           cap_we_i,
  input  logic [sai_pkg::CAP_W-1:0]      cap_wdata_i,
  input  logic [sai_pkg::MODE_W-1:0]     mode_i,
  input  logic [sai_pkg::KEY_W-1:0]      key_i,
  input  logic [sai_pkg::INDEX_W-1:0]    index_i,
  output logic                           done_o,
  output logic [sai_pkg::KEY_W-1:0]      read_value_o,
  output logic [sai_pkg::POS_W-1:0]      position_o,
  output logic [sai_pkg::COUNT_W-1:0]    count_o,
  output logic [sai_pkg::STATUS_W-1:0]   status_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > sai_pkg::CAP_W) ? CW : sai_pkg::CAP_W;
  localparam int KW   = KEY_WIDTH;

  // Control state.
  logic [sai_pkg::CAP_W-1:0] cap_q;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             hwm_q, hwm_d;
  logic                      done_q;

  // Request operands and working registers.
  sai_pkg::mode_e            mode_q;
  sai_pkg::status_e          st_q, st_d;
  logic                      skip_q, skip_d;
  logic [KW-1:0]             key_q;
  logic [sai_pkg::INDEX_W-1:0] idx_q;
  logic [CW-1:0]             ptr_q;
  logic [CW-1:0]             pos_q;
  logic [KW-1:0]             rv_q;

  // Result registers.
  logic [sai_pkg::KEY_W-1:0]   read_value_q;
  logic [sai_pkg::POS_W-1:0]   position_q;
  logic [sai_pkg::COUNT_W-1:0] count_out_q;
  sai_pkg::status_e            status_q;

  logic [KW+sai_pkg::KEY_W-1:0] key_ext, rv_ext;
  logic [KW-1:0]   key_w;
  logic [CMPW-1:0] cap_eff, cnt_ext, idx_in_ext;
  logic [CW:0]     ptr_p1;
  logic            rd_last, step_last, key_ge;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [KW-1:0]   ram_wdata, ram_rdata;

  assign key_ext = {{KW{1'b0}}, key_i};
  assign key_w   = key_ext[KW-1:0];
  assign rv_ext  = {{sai_pkg::KEY_W{1'b0}}, rv_q};

  assign cap_eff    = (CMPW'(cap_q) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(cap_q);
  assign cnt_ext    = CMPW'(count_q);
  assign idx_in_ext = CMPW'(index_i);
  assign ptr_p1     = {1'b0, ptr_q} + (CW+1)'(1);
  assign key_ge     = (ram_rdata >= key_q);

  // Classify the request at load time: which ones fail or do nothing.
  always_comb begin
    st_d   = sai_pkg::ST_OK;
    skip_d = 1'b0;
    case (sai_pkg::mode_e'(mode_i))
      sai_pkg::MODE_INSERT: begin
        if (cnt_ext >= cap_eff) begin
          st_d   = sai_pkg::ST_FULL;
          skip_d = 1'b1;
        end
      end
      sai_pkg::MODE_REMOVE: begin
        if (idx_in_ext >= cnt_ext) begin
          st_d   = sai_pkg::ST_RANGE;
          skip_d = 1'b1;
        end
      end
      sai_pkg::MODE_GET: begin
        if (idx_in_ext >= cap_eff) begin
          st_d   = sai_pkg::ST_RANGE;
          skip_d = 1'b1;
        end
      end
      default: begin
        skip_d = 1'b1;
      end
    endcase
  end

  // Insert walks down from the top, moving entries up until a smaller key
  // is found. Remove walks up, pulling entries down. Slots at or above the
  // high-water mark were never written and read as zero.
  always_comb begin
    case (mode_q)
      sai_pkg::MODE_INSERT: begin
        rd_last   = (ptr_q == '0);
        step_last = !key_ge;
      end
      sai_pkg::MODE_REMOVE: begin
        rd_last   = (ptr_p1 >= {1'b0, count_q});
        step_last = 1'b0;
      end
      sai_pkg::MODE_GET: begin
        rd_last   = (CMPW'(idx_q) >= CMPW'(hwm_q));
        step_last = 1'b1;
      end
      default: begin
        rd_last   = 1'b1;
        step_last = 1'b1;
      end
    endcase
  end

  assign stat_o.skip      = skip_q;
  assign stat_o.rd_last   = rd_last;
  assign stat_o.step_last = step_last;

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = AW'(ptr_q);
    ram_raddr = AW'(idx_q);
    ram_wdata = key_q;
    if (cmd_i.rd && !skip_q) begin
      if (rd_last) begin
        // Insert reached the bottom slot: every stored key is not less.
        ram_we = (mode_q == sai_pkg::MODE_INSERT);
      end else begin
        ram_re = 1'b1;
        case (mode_q)
          sai_pkg::MODE_INSERT: ram_raddr = AW'(ptr_q - CW'(1));
          sai_pkg::MODE_REMOVE: ram_raddr = AW'(ptr_p1);
          default:              ram_raddr = AW'(idx_q);
        endcase
      end
    end
    if (cmd_i.step) begin
      case (mode_q)
        sai_pkg::MODE_INSERT: begin
          ram_we    = 1'b1;
          ram_wdata = key_ge ? ram_rdata : key_q;
        end
        sai_pkg::MODE_REMOVE: begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    hwm_d   = hwm_q;
    if (!skip_q) begin
      case (mode_q)
        sai_pkg::MODE_INSERT: begin
          count_d = count_q + CW'(1);
          if (count_d > hwm_q) begin
            hwm_d = count_d;
          end
        end
        sai_pkg::MODE_REMOVE: count_d = count_q - CW'(1);
        default:              count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= sai_pkg::CAP_RESET;
      count_q <= '0;
      hwm_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cap_we_i) begin
        cap_q <= cap_wdata_i;
      end
      if (cmd_i.done) begin
        count_q <= count_d;
        hwm_q   <= hwm_d;
      end
      done_q <= cmd_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= sai_pkg::mode_e'(mode_i);
      key_q  <= key_w;
      idx_q  <= index_i;
      st_q   <= st_d;
      skip_q <= skip_d;
      pos_q  <= '0;
      rv_q   <= '0;
      if (sai_pkg::mode_e'(mode_i) == sai_pkg::MODE_INSERT) begin
        ptr_q <= count_q;
      end else begin
        ptr_q <= CW'(index_i);
      end
    end
    if (cmd_i.step) begin
      case (mode_q)
        sai_pkg::MODE_INSERT: begin
          if (key_ge) begin
            ptr_q <= ptr_q - CW'(1);
          end else begin
            pos_q <= ptr_q;
          end
        end
        sai_pkg::MODE_REMOVE: ptr_q <= CW'(ptr_p1);
        default:              rv_q  <= ram_rdata;
      endcase
    end
    if (cmd_i.done) begin
      read_value_q <= rv_ext[sai_pkg::KEY_W-1:0];
      position_q   <= sai_pkg::POS_W'(pos_q);
      count_out_q  <= sai_pkg::COUNT_W'(count_d);
      status_q     <= st_q;
    end
  end

  sai_ram #(
    .WIDTH (KW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o       = done_q;
  assign read_value_o = read_value_q;
  assign position_o   = position_q;
  assign count_o      = count_out_q;
  assign status_o     = status_q;

  `SAI_ASSERT(a_count_le_hwm, clk_i, rst_ni, count_q <= hwm_q, "count above high-water mark")
  `SAI_ASSERT(a_hwm_le_depth, clk_i, rst_ni, CMPW'(hwm_q) <= CMPW'(DEPTH), "high-water mark above depth")
  `SAI_ASSERT_NEXT(a_done_strobe, clk_i, rst_ni, cmd_i.done, done_q, "missing result strobe")
  `SAI_ASSERT_IMPL(a_full_keeps_count, clk_i, rst_ni, done_q && status_q == sai_pkg::ST_FULL, $stable(count_q), "full insert changed count")

endmodule

// File: rtl/core/sorted_array_insert_remove.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// request   in         start / busy       mode_i, key_i, index_i
// result    out        done_o (strobe)    read_value_o, position_o, count_o, status_o
// config    in         cap_we_i           cap_wdata_i (capacity)
//
// A request is taken when start is high and busy is low; its result shows for one
// cycle under done_o, and the next request may be taken in that same cycle.
// Each entry that an insert or remove moves is read in the read state and written in the
// step state, one read and one write through the single-port-pair table RAM. A get reads
// its slot in a read and a step state; a get of a slot never written since reset and a
// rejected request go from the read state straight to the finish state.
// Reset clears the count and high-water mark at once; no clearing pass is needed.
// The result side cannot stall, so results are never held back.
module sorted_array_insert_remove #(
  parameter int DEPTH     = sai_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = sai_pkg::KEY_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [sai_pkg::MODE_W-1:0]   mode_i,
  input  logic [sai_pkg::KEY_W-1:0]    key_i,
  input  logic [sai_pkg::INDEX_W-1:0]  index_i,
  output logic                         done_o,
  output logic [sai_pkg::KEY_W-1:0]    read_value_o,
  output logic [sai_pkg::POS_W-1:0]    position_o,
  output logic [sai_pkg::COUNT_W-1:0]  count_o,
  output logic [sai_pkg::STATUS_W-1:0] status_o,
  input  logic                         cap_we_i,
  input  logic [sai_pkg::CAP_W-1:0]    cap_wdata_i
);

  sai_pkg::sai_cmd_t  cmd;
  sai_pkg::sai_stat_t stat;

  sai_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  sai_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cap_we_i     (cap_we_i),
    .cap_wdata_i  (cap_wdata_i),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .index_i      (index_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .position_o   (position_o),
    .count_o      (count_o),
    .status_o     (status_o)
  );

endmodule
